// File: hdl/trpc_pkg.sv
`timescale 1ns / 1ps

package trpc_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CoordW  = 12;  // three hex digits
  localparam int unsigned OffW    = 13;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned ResW    = 12;
  localparam int unsigned OutW    = 21;
  localparam int unsigned DiffW   = 15;  // rotated coordinate minus offset
  localparam int unsigned ProdW   = DiffW + ScaleW;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned DataW   = 32;

  // Line layout
  localparam int unsigned LineKeep = 7;
  localparam int unsigned CommaPos = 3;
  localparam int unsigned YStart   = 4;

  // Character codes
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLow   = 8'h20;
  localparam logic [ByteW-1:0] ChHigh  = 8'h7E;

  // Unity gain in Q7.8
  localparam logic signed [ScaleW-1:0] ScaleOne = 16'sd256;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [IdxW-1:0] {
    REG_CALIBRATED = 8'd0,
    REG_ROTATION   = 8'd1,
    REG_OFFSET_X   = 8'd2,
    REG_OFFSET_Y   = 8'd3,
    REG_SCALE_X    = 8'd4,
    REG_SCALE_Y    = 8'd5,
    REG_X_RES      = 8'd6,
    REG_Y_RES      = 8'd7
  } reg_idx_e;

  typedef struct packed {
    logic                     calibrated;
    rot_e                     rotation;
    logic signed [OffW-1:0]   x_off;
    logic signed [OffW-1:0]   y_off;
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic [ResW-1:0]          x_res;
    logic [ResW-1:0]          y_res;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

  // Hex digit decode: {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Leading hex digits of a three-character field
  function automatic logic [CoordW-1:0] parse_field(input logic [ByteW-1:0] c0,
                                                    input logic [ByteW-1:0] c1,
                                                    input logic [ByteW-1:0] c2);
    logic [4:0] d0;
    logic [4:0] d1;
    logic [4:0] d2;
    logic [CoordW-1:0] r;
    d0 = hex_digit(c0);
    d1 = hex_digit(c1);
    d2 = hex_digit(c2);
    if (!d0[4]) begin
      r = '0;
    end else if (!d1[4]) begin
      r = {8'd0, d0[3:0]};
    end else if (!d2[4]) begin
      r = {4'd0, d0[3:0], d1[3:0]};
    end else begin
      r = {d0[3:0], d1[3:0], d2[3:0]};
    end
    return r;
  endfunction

endpackage

// File: hdl/touch_report_parse_calibrate_top.sv
`timescale 1ns / 1ps

// Touch report parser with calibration.
// Input channel: one byte per transaction on rx_byte_i (in_valid_i / in_stall_o).
// Printable bytes build a line; CR or LF closes it, as does reaching
// LINE_CAPACITY characters. A line of seven characters with a comma in the
// fourth place gives one point transaction on touch_x_o / touch_y_o
// (out_valid_o / out_stall_i); any other line gives nothing.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, writes to unknown indexes are ignored.
// Points pass the hex decode register at the accepting edge, then the rotate
// and offset, multiply and round registers. One byte is taken every cycle
// unless stalled; the pipeline is elastic, so a stalled result only holds
// the input back once every stage behind it is full.
// Reset clears the line count, the pipeline valids and restores the
// default configuration (raw coordinates, unity gain, 1024 resolution).

module touch_report_parse_calibrate_top import trpc_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ByteW-1:0]       rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] touch_x_o,
  output logic signed [OutW-1:0] touch_y_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IdxW-1:0]        cfg_index_i,
  input  logic [DataW-1:0]       cfg_data_i
);

  cfg_t   cfg;
  logic   pt_valid;
  logic   pt_ready;
  point_t pt;

  trpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  trpc_line_parser #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .pt_valid_o (pt_valid),
    .pt_ready_i (pt_ready),
    .pt_o       (pt)
  );

  trpc_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_i        (pt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .touch_x_o   (touch_x_o),
    .touch_y_o   (touch_y_o)
  );

endmodule

// File: hdl/trpc_cfg_regs.sv
`timescale 1ns / 1ps

module trpc_cfg_regs import trpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode; upper data bits are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CALIBRATED: cfg_d.calibrated = cfg_data_i[0];
        REG_ROTATION:   cfg_d.rotation   = rot_e'(cfg_data_i[1:0]);
        REG_OFFSET_X:   cfg_d.x_off      = cfg_data_i[OffW-1:0];
        REG_OFFSET_Y:   cfg_d.y_off      = cfg_data_i[OffW-1:0];
        REG_SCALE_X:    cfg_d.scale_x    = cfg_data_i[ScaleW-1:0];
        REG_SCALE_Y:    cfg_d.scale_y    = cfg_data_i[ScaleW-1:0];
        REG_X_RES:      cfg_d.x_res      = cfg_data_i[ResW-1:0];
        REG_Y_RES:      cfg_d.y_res      = cfg_data_i[ResW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibrated <= 1'b0;
      cfg_q.rotation   <= ROT_0;
      cfg_q.x_off      <= '0;
      cfg_q.y_off      <= '0;
      cfg_q.scale_x    <= ScaleOne;
      cfg_q.scale_y    <= ScaleOne;
      cfg_q.x_res      <= 12'd1024;
      cfg_q.y_res      <= 12'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/trpc_line_parser.sv
`timescale 1ns / 1ps

module trpc_line_parser import trpc_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             pt_valid_o,
  input  logic             pt_ready_i,
  output point_t           pt_o
);

  localparam int unsigned CntW = $clog2(LINE_CAPACITY + 1);
  localparam logic [CntW-1:0] CntCap  = CntW'(LINE_CAPACITY);
  localparam logic [CntW-1:0] CntKeep = CntW'(LineKeep);

  logic [ByteW-1:0] chars_q [LineKeep];
  logic [CntW-1:0]  count_q, count_d;
  logic             pt_valid_q, pt_valid_d;
  point_t           pt_q;

  logic            accept;
  logic            printable;
  logic            eol;
  logic [CntW-1:0] count_inc;
  logic            close;
  logic            good_line;

  // Output register holds a point until the calibration stage takes it
  assign in_stall_o = pt_valid_q && !pt_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign printable = (rx_byte_i >= ChLow) && (rx_byte_i <= ChHigh);
  assign eol       = (rx_byte_i == ChLf) || (rx_byte_i == ChCr);
  assign count_inc = count_q + CntW'(printable);
  assign close     = eol || (count_inc >= CntCap);
  assign good_line = close && (count_inc == CntKeep) && (chars_q[CommaPos] == ChComma);

  // Line count
  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = close ? '0 : count_inc;
    end
  end

  // Point register handshake
  always_comb begin
    pt_valid_d = pt_valid_q;
    if (pt_ready_i) begin
      pt_valid_d = 1'b0;
    end
    if (accept && good_line) begin
      pt_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pt_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      pt_valid_q <= pt_valid_d;
    end
  end

  // Character store: only the first seven characters are kept
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LineKeep; i++) begin
      if (accept && printable && (count_q == CntW'(i))) begin
        chars_q[i] <= rx_byte_i;
      end
    end
  end

  // Hex decode of both fields
  always_ff @(posedge clk_i) begin
    if (accept && good_line) begin
      pt_q.x <= parse_field(chars_q[0], chars_q[1], chars_q[2]);
      pt_q.y <= parse_field(chars_q[YStart], chars_q[YStart+1], chars_q[YStart+2]);
    end
  end

  assign pt_valid_o = pt_valid_q;
  assign pt_o       = pt_q;

endmodule

// File: hdl/trpc_calib.sv
`timescale 1ns / 1ps

module trpc_calib import trpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  pt_valid_i,
  output logic                  pt_ready_o,
  input  point_t                pt_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [OutW-1:0] touch_x_o,
  output logic signed [OutW-1:0] touch_y_o
);

  // Stage valids: rotate/offset, multiply, round/output
  logic rot_valid_q, mul_valid_q, out_valid_q;
  logic rot_ready, mul_ready, out_ready;

  logic signed [DiffW-1:0]  diff_x_q, diff_y_q;
  logic signed [ScaleW-1:0] gain_x_q, gain_y_q;
  logic signed [ProdW-1:0]  prod_x_q, prod_y_q;
  logic signed [OutW-1:0]   res_x_q, res_y_q;

  logic signed [DiffW-1:0] px, py, xres, yres, rx, ry;
  logic signed [DiffW-1:0] off_x, off_y;
  logic signed [ProdW-1:0] bias_x, bias_y, sum_x, sum_y;

  // Elastic pipeline: a stage moves when it is empty or the next moves
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign mul_ready  = !mul_valid_q || out_ready;
  assign rot_ready  = !rot_valid_q || mul_ready;
  assign pt_ready_o = rot_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rot_ready) rot_valid_q <= pt_valid_i;
      if (mul_ready) mul_valid_q <= rot_valid_q;
      if (out_ready) out_valid_q <= mul_valid_q;
    end
  end

  // Rotation against the resolutions, then offset
  assign px   = DiffW'($signed({1'b0, pt_i.x}));
  assign py   = DiffW'($signed({1'b0, pt_i.y}));
  assign xres = DiffW'($signed({1'b0, cfg_i.x_res}));
  assign yres = DiffW'($signed({1'b0, cfg_i.y_res}));
  assign off_x = DiffW'(cfg_i.x_off);
  assign off_y = DiffW'(cfg_i.y_off);

  always_comb begin
    case (cfg_i.rotation)
      ROT_90: begin
        rx = yres - py;
        ry = px;
      end
      ROT_180: begin
        rx = xres - px;
        ry = yres - py;
      end
      ROT_270: begin
        rx = py;
        ry = xres - px;
      end
      default: begin
        rx = px;
        ry = py;
      end
    endcase
  end

  // Raw mode runs through the same path at unity gain
  always_ff @(posedge clk_i) begin
    if (rot_ready && pt_valid_i) begin
      if (cfg_i.calibrated) begin
        diff_x_q <= rx - off_x;
        diff_y_q <= ry - off_y;
        gain_x_q <= cfg_i.scale_x;
        gain_y_q <= cfg_i.scale_y;
      end else begin
        diff_x_q <= px;
        diff_y_q <= py;
        gain_x_q <= ScaleOne;
        gain_y_q <= ScaleOne;
      end
    end
  end

  // Gain multiply
  always_ff @(posedge clk_i) begin
    if (mul_ready && rot_valid_q) begin
      prod_x_q <= ProdW'(diff_x_q) * ProdW'(gain_x_q);
      prod_y_q <= ProdW'(diff_y_q) * ProdW'(gain_y_q);
    end
  end

  // Divide by 256 truncating toward zero
  assign bias_x = prod_x_q[ProdW-1] ? ProdW'(255) : '0;
  assign bias_y = prod_y_q[ProdW-1] ? ProdW'(255) : '0;
  assign sum_x  = (prod_x_q + bias_x) >>> 8;
  assign sum_y  = (prod_y_q + bias_y) >>> 8;

  always_ff @(posedge clk_i) begin
    if (out_ready && mul_valid_q) begin
      res_x_q <= sum_x[OutW-1:0];
      res_y_q <= sum_y[OutW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign touch_x_o   = res_x_q;
  assign touch_y_o   = res_y_q;

endmodule

// File: hdl/trpc_checker.sv
`timescale 1ns / 1ps

module trpc_checker import trpc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [OutW-1:0] touch_x_o,
  input logic signed [OutW-1:0] touch_y_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(touch_x_o) && $stable(touch_y_o))
    else $error("result changed while stalled");

  // Input backpressure only ever comes from a stalled, pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Register writes are never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind touch_report_parse_calibrate_top trpc_checker u_trpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .touch_x_o   (touch_x_o),
  .touch_y_o   (touch_y_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
